### src/i2crm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2crm_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_HALF_BIT_TICKS = 2'd1;
	localparam logic [1:0] CFG_ACK_POLL_LIMIT = 2'd2;

	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd104;
	localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd10;
	localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

	// Request types.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Which byte of the bus script is being sent.
	localparam logic [2:0] STG_ADDR_WR = 3'd0;
	localparam logic [2:0] STG_REG     = 3'd1;
	localparam logic [2:0] STG_DATA    = 3'd2;
	localparam logic [2:0] STG_ADDR_RD = 3'd3;
	localparam logic [2:0] STG_READ    = 3'd4;

	// Bus phases.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ST_HI  = 4'd1,
		PH_ST_LO  = 4'd2,
		PH_TX_LO  = 4'd3,
		PH_TX_HI  = 4'd4,
		PH_ACK_LO = 4'd5,
		PH_ACK_HI = 4'd6,
		PH_RX_LO  = 4'd7,
		PH_RX_HI  = 4'd8,
		PH_MA_LO  = 4'd9,
		PH_MA_HI  = 4'd10,
		PH_RS_LO  = 4'd11,
		PH_SP_LO  = 4'd12,
		PH_SP_HI  = 4'd13,
		PH_SP_REL = 4'd14
	} phase_t;

	// One tick of input.
	typedef struct packed {
		logic       start_request;
		logic       req_type;
		logic [7:0] target_reg;
		logic [7:0] wr_data;
		logic [7:0] byte_count;
		logic       sda_in;
	} req_t;

	// One tick of output.
	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic       rd_last;
		logic       done_res;
		logic       ack_error;
	} res_t;

endpackage
`default_nettype wire

### src/i2crm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface i2crm_req_if;
	logic              valid;
	logic              ready;
	i2crm_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/i2crm_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface i2crm_res_if;
	logic              valid;
	logic              ready;
	i2crm_pkg::res_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/i2c_register_master.sv
`timescale 1ns / 1ps
`default_nettype none
// I2C register master, stepped by one tick transaction per clock while req.ready is high.
// The req channel carries one timing tick: a start request with its
// register write or burst read parameters, and the sampled SDA level.
// Each accepted tick yields exactly one transaction on the res channel
// with the SCL level, the open-drain SDA pull, busy, a received byte
// with its last flag, and done with the ACK error flag.
// The result of an accepted tick is registered in the output register, or in
// the skid register while res stalls. Throughput: one tick per cycle while
// req.ready is high; the bus sequencer update is a single pass of logic
// between the state registers and the result register.
// When res stalls, one further tick is taken into a skid register and
// req.ready then drops until the stall clears; no result is lost.
// The cfg port (cfg_we, cfg_index, cfg_data) writes one of device_address,
// half_bit_ticks and ack_poll_limit, chosen by cfg_index; unknown indexes are ignored.
// Reset (arst_n low) returns the sequencer to idle (SCL high, SDA
// released), empties both output registers and restores the register
// defaults: address 104, 10 ticks per half bit, 250 ACK polls.
module i2c_register_master (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [i2crm_pkg::CFG_DATA_W-1:0] cfg_data,
	i2crm_req_if.sink                             req,
	i2crm_res_if.source                           res
);

	// Configuration registers.
	logic [6:0]  device_address_q;
	logic [15:0] half_bit_ticks_q;
	logic [7:0]  ack_poll_limit_q;

	// Sequencer state.
	i2crm_pkg::phase_t phase_q, phase_d;
	logic [15:0] delay_q, delay_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  poll_q, poll_d;
	logic [2:0]  stage_q, stage_d;
	logic        err_q, err_d;
	logic        lt_type_q, lt_type_d;
	logic [7:0]  lt_reg_q, lt_reg_d;
	logic [7:0]  lt_wr_q, lt_wr_d;

	// Output register and skid register.
	logic              out_valid_q;
	i2crm_pkg::res_t   out_q;
	logic              skid_valid_q;
	i2crm_pkg::res_t   skid_q;

	i2crm_pkg::res_t   res_d;
	logic              accept;
	logic              out_free;
	logic [15:0]       h;
	logic [7:0]        lim;
	logic [16:0]       delay_inc;
	logic              seg_end;

	assign req.ready = !skid_valid_q;
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// Zero delay and poll limits behave as one.
	assign h   = (half_bit_ticks_q == 16'd0) ? 16'd1 : half_bit_ticks_q;
	assign lim = (ack_poll_limit_q == 8'd0) ? 8'd1 : ack_poll_limit_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= i2crm_pkg::DEVICE_ADDRESS_RST;
			half_bit_ticks_q <= i2crm_pkg::HALF_BIT_TICKS_RST;
			ack_poll_limit_q <= i2crm_pkg::ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2crm_pkg::CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[6:0];
				i2crm_pkg::CFG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data[15:0];
				i2crm_pkg::CFG_ACK_POLL_LIMIT: ack_poll_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Next state and result of one tick.
	always_comb begin
		phase_d   = phase_q;
		delay_d   = delay_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		left_d    = left_q;
		poll_d    = poll_q;
		stage_d   = stage_q;
		err_d     = err_q;
		lt_type_d = lt_type_q;
		lt_reg_d  = lt_reg_q;
		lt_wr_d   = lt_wr_q;
		res_d     = '0;
		res_d.scl_level = 1'b1;

		// A start request in idle latches the request and begins a START.
		if (phase_q == i2crm_pkg::PH_IDLE && req.data.start_request) begin
			lt_type_d = req.data.req_type;
			lt_reg_d  = req.data.target_reg;
			lt_wr_d   = req.data.wr_data;
			left_d    = (req.data.byte_count == 8'd0) ? 8'd1 : req.data.byte_count;
			stage_d   = i2crm_pkg::STG_ADDR_WR;
			err_d     = 1'b0;
			poll_d    = 8'd0;
			delay_d   = 16'd0;
			shift_d   = {device_address_q, 1'b0};
			bit_d     = 3'd0;
			phase_d   = i2crm_pkg::PH_ST_HI;
		end

		delay_inc = {1'b0, delay_d} + 17'd1;
		seg_end   = delay_inc >= {1'b0, h};

		if (phase_d != i2crm_pkg::PH_IDLE) begin
			res_d.busy_res = 1'b1;

			// Bus levels of the current phase.
			case (phase_d)
				i2crm_pkg::PH_ST_HI: begin
					res_d.scl_level = 1'b1; res_d.sda_pull_low = 1'b0;
				end
				i2crm_pkg::PH_ST_LO: begin
					res_d.scl_level = 1'b1; res_d.sda_pull_low = 1'b1;
				end
				i2crm_pkg::PH_TX_LO: begin
					res_d.scl_level = 1'b0; res_d.sda_pull_low = !shift_d[7];
				end
				i2crm_pkg::PH_TX_HI: begin
					res_d.scl_level = 1'b1; res_d.sda_pull_low = !shift_d[7];
				end
				i2crm_pkg::PH_ACK_LO, i2crm_pkg::PH_RX_LO, i2crm_pkg::PH_RS_LO: begin
					res_d.scl_level = 1'b0; res_d.sda_pull_low = 1'b0;
				end
				i2crm_pkg::PH_MA_LO: begin
					res_d.scl_level = 1'b0; res_d.sda_pull_low = left_d > 8'd1;
				end
				i2crm_pkg::PH_MA_HI: begin
					res_d.scl_level = 1'b1; res_d.sda_pull_low = left_d > 8'd1;
				end
				i2crm_pkg::PH_SP_LO: begin
					res_d.scl_level = 1'b0; res_d.sda_pull_low = 1'b1;
				end
				i2crm_pkg::PH_SP_HI: begin
					res_d.scl_level = 1'b1; res_d.sda_pull_low = 1'b1;
				end
				default: begin
					res_d.scl_level = 1'b1; res_d.sda_pull_low = 1'b0;
				end
			endcase

			if (phase_d == i2crm_pkg::PH_ACK_HI) begin
				// ACK slot: wait a half bit, then poll SDA once per tick.
				if (!seg_end) begin
					delay_d = delay_inc[15:0];
				end else if (!req.data.sda_in) begin
					delay_d = 16'd0;
					poll_d  = 8'd0;
					bit_d   = 3'd0;
					case (stage_d)
						i2crm_pkg::STG_ADDR_WR: begin
							stage_d = i2crm_pkg::STG_REG;
							shift_d = lt_reg_d;
							phase_d = i2crm_pkg::PH_TX_LO;
						end
						i2crm_pkg::STG_REG: begin
							if (lt_type_d == i2crm_pkg::REQ_READ) begin
								stage_d = i2crm_pkg::STG_ADDR_RD;
								shift_d = {device_address_q, 1'b1};
								phase_d = i2crm_pkg::PH_RS_LO;
							end else begin
								stage_d = i2crm_pkg::STG_DATA;
								shift_d = lt_wr_d;
								phase_d = i2crm_pkg::PH_TX_LO;
							end
						end
						i2crm_pkg::STG_ADDR_RD: begin
							stage_d = i2crm_pkg::STG_READ;
							shift_d = 8'd0;
							phase_d = i2crm_pkg::PH_RX_LO;
						end
						default: begin
							bit_d   = bit_q;
							phase_d = i2crm_pkg::PH_SP_LO;
						end
					endcase
				end else begin
					poll_d = poll_d + 8'd1;
					if (poll_d >= lim) begin
						err_d   = 1'b1;
						delay_d = 16'd0;
						poll_d  = 8'd0;
						phase_d = i2crm_pkg::PH_SP_LO;
					end
				end
			end else if (!seg_end) begin
				delay_d = delay_inc[15:0];
			end else begin
				// End of a bus level: step to the next phase.
				delay_d = 16'd0;
				case (phase_d)
					i2crm_pkg::PH_RS_LO: phase_d = i2crm_pkg::PH_ST_HI;
					i2crm_pkg::PH_ST_HI: phase_d = i2crm_pkg::PH_ST_LO;
					i2crm_pkg::PH_ST_LO: phase_d = i2crm_pkg::PH_TX_LO;
					i2crm_pkg::PH_TX_LO: phase_d = i2crm_pkg::PH_TX_HI;
					i2crm_pkg::PH_TX_HI: begin
						if (bit_d == 3'd7) begin
							phase_d = i2crm_pkg::PH_ACK_LO;
						end else begin
							bit_d   = bit_d + 3'd1;
							shift_d = {shift_d[6:0], 1'b0};
							phase_d = i2crm_pkg::PH_TX_LO;
						end
					end
					i2crm_pkg::PH_ACK_LO: begin
						poll_d  = 8'd0;
						phase_d = i2crm_pkg::PH_ACK_HI;
					end
					i2crm_pkg::PH_RX_LO: phase_d = i2crm_pkg::PH_RX_HI;
					i2crm_pkg::PH_RX_HI: begin
						shift_d = {shift_d[6:0], req.data.sda_in};
						if (bit_d == 3'd7) begin
							res_d.rd_valid = 1'b1;
							res_d.rd_data  = shift_d;
							res_d.rd_last  = left_d <= 8'd1;
							phase_d        = i2crm_pkg::PH_MA_LO;
						end else begin
							bit_d   = bit_d + 3'd1;
							phase_d = i2crm_pkg::PH_RX_LO;
						end
					end
					i2crm_pkg::PH_MA_LO: phase_d = i2crm_pkg::PH_MA_HI;
					i2crm_pkg::PH_MA_HI: begin
						if (left_d <= 8'd1) begin
							phase_d = i2crm_pkg::PH_SP_LO;
						end else begin
							left_d  = left_d - 8'd1;
							shift_d = 8'd0;
							bit_d   = 3'd0;
							phase_d = i2crm_pkg::PH_RX_LO;
						end
					end
					i2crm_pkg::PH_SP_LO: phase_d = i2crm_pkg::PH_SP_HI;
					i2crm_pkg::PH_SP_HI: phase_d = i2crm_pkg::PH_SP_REL;
					default: begin
						res_d.done_res  = 1'b1;
						res_d.ack_error = err_d;
						phase_d         = i2crm_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2crm_pkg::PH_IDLE;
			delay_q   <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			left_q    <= '0;
			poll_q    <= '0;
			stage_q   <= i2crm_pkg::STG_ADDR_WR;
			err_q     <= 1'b0;
			lt_type_q <= 1'b0;
			lt_reg_q  <= '0;
			lt_wr_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			delay_q   <= delay_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			left_q    <= left_d;
			poll_q    <= poll_d;
			stage_q   <= stage_d;
			err_q     <= err_d;
			lt_type_q <= lt_type_d;
			lt_reg_q  <= lt_reg_d;
			lt_wr_q   <= lt_wr_d;
		end
	end

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

endmodule
`default_nettype wire

### tb/i2c_register_master_tb.sv
`timescale 1ns / 1ps
module i2c_register_master_tb;
	import i2crm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	i2crm_req_if req ();
	i2crm_res_if res ();

	i2c_register_master u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req),
		.res(res)
	);

	// Mirror of the configuration registers.
	logic [6:0] dev_addr = DEVICE_ADDRESS_RST;
	logic [15:0] half_bit = HALF_BIT_TICKS_RST;
	logic [7:0] poll_limit = ACK_POLL_LIMIT_RST;

	// Mirror of the bus sequencer state.
	phase_t bus_phase = PH_IDLE;
	logic [15:0] tick_count = '0;
	logic [2:0] bit_pos = '0;
	logic [7:0] shift_reg = '0;
	logic [7:0] bytes_to_read = '0;
	logic [7:0] ack_polls = '0;
	logic [2:0] script_stage = STG_ADDR_WR;
	logic nack_seen = 1'b0;
	logic held_type = REQ_WRITE;
	logic [7:0] held_reg = '0;
	logic [7:0] held_data = '0;

	// Bus levels still owed by the block, oldest first.
	res_t bus_outputs_due[$];

	int unsigned mismatches = 0;
	int unsigned ticks_checked = 0;
	int unsigned cycles = 0;

	// Knobs for the stimulus and the two sides of the handshake.
	int unsigned req_max_gap = 15;
	int unsigned res_max_stall = 15;
	int unsigned start_pct = 70;
	int unsigned absent_pct = 10;
	logic slave_absent = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL i2c_register_master");
			$finish;
		end
	end

	// Advance the sequencer mirror by one tick and return the bus levels it drives.
	function automatic res_t advance_bus(input req_t t);
		res_t o;
		int unsigned hb;
		int unsigned lim;
		o = '0;
		o.scl_level = 1'b1;
		hb = (half_bit == 16'd0) ? 1 : half_bit;
		lim = (poll_limit == 8'd0) ? 1 : poll_limit;

		// A request is only taken while the bus is idle.
		if (bus_phase == PH_IDLE && t.start_request) begin
			held_type = t.req_type;
			held_reg = t.target_reg;
			held_data = t.wr_data;
			bytes_to_read = (t.byte_count == 8'd0) ? 8'd1 : t.byte_count;
			script_stage = STG_ADDR_WR;
			nack_seen = 1'b0;
			ack_polls = '0;
			tick_count = '0;
			shift_reg = {dev_addr, 1'b0};
			bit_pos = '0;
			bus_phase = PH_ST_HI;
		end

		if (bus_phase != PH_IDLE) begin
			o.busy_res = 1'b1;
			case (bus_phase)
				PH_ST_LO: begin
					o.sda_pull_low = 1'b1;
				end
				PH_TX_LO: begin
					o.scl_level = 1'b0;
					o.sda_pull_low = ~shift_reg[7];
				end
				PH_TX_HI: begin
					o.sda_pull_low = ~shift_reg[7];
				end
				PH_ACK_LO, PH_RX_LO, PH_RS_LO: begin
					o.scl_level = 1'b0;
				end
				PH_MA_LO: begin
					o.scl_level = 1'b0;
					o.sda_pull_low = bytes_to_read > 8'd1;
				end
				PH_MA_HI: begin
					o.sda_pull_low = bytes_to_read > 8'd1;
				end
				PH_SP_LO: begin
					o.scl_level = 1'b0;
					o.sda_pull_low = 1'b1;
				end
				PH_SP_HI: begin
					o.sda_pull_low = 1'b1;
				end
				default: ;
			endcase

			if (bus_phase == PH_ACK_HI) begin
				// Hold SCL high for one half bit, then poll SDA once per tick.
				if (tick_count + 1 < hb) begin
					tick_count = tick_count + 16'd1;
				end else if (!t.sda_in) begin
					tick_count = '0;
					ack_polls = '0;
					bit_pos = '0;
					case (script_stage)
						STG_ADDR_WR: begin
							script_stage = STG_REG;
							shift_reg = held_reg;
							bus_phase = PH_TX_LO;
						end
						STG_REG: begin
							if (held_type == REQ_READ) begin
								script_stage = STG_ADDR_RD;
								shift_reg = {dev_addr, 1'b1};
								bus_phase = PH_RS_LO;
							end else begin
								script_stage = STG_DATA;
								shift_reg = held_data;
								bus_phase = PH_TX_LO;
							end
						end
						STG_ADDR_RD: begin
							script_stage = STG_READ;
							shift_reg = '0;
							bus_phase = PH_RX_LO;
						end
						default: begin
							bus_phase = PH_SP_LO;
						end
					endcase
				end else begin
					ack_polls = ack_polls + 8'd1;
					if (ack_polls >= lim) begin
						nack_seen = 1'b1;
						tick_count = '0;
						ack_polls = '0;
						bus_phase = PH_SP_LO;
					end
				end
			end else if (tick_count + 1 < hb) begin
				tick_count = tick_count + 16'd1;
			end else begin
				tick_count = '0;
				case (bus_phase)
					PH_RS_LO: bus_phase = PH_ST_HI;
					PH_ST_HI: bus_phase = PH_ST_LO;
					PH_ST_LO: bus_phase = PH_TX_LO;
					PH_TX_LO: bus_phase = PH_TX_HI;
					PH_TX_HI: begin
						if (bit_pos == 3'd7) begin
							bus_phase = PH_ACK_LO;
						end else begin
							bit_pos = bit_pos + 3'd1;
							shift_reg = shift_reg << 1;
							bus_phase = PH_TX_LO;
						end
					end
					PH_ACK_LO: begin
						ack_polls = '0;
						bus_phase = PH_ACK_HI;
					end
					PH_RX_LO: bus_phase = PH_RX_HI;
					PH_RX_HI: begin
						// Sample SDA at the end of the high half, MSB first.
						shift_reg = {shift_reg[6:0], t.sda_in};
						if (bit_pos == 3'd7) begin
							o.rd_valid = 1'b1;
							o.rd_data = shift_reg;
							o.rd_last = bytes_to_read <= 8'd1;
							bus_phase = PH_MA_LO;
						end else begin
							bit_pos = bit_pos + 3'd1;
							bus_phase = PH_RX_LO;
						end
					end
					PH_MA_LO: bus_phase = PH_MA_HI;
					PH_MA_HI: begin
						if (bytes_to_read <= 8'd1) begin
							bus_phase = PH_SP_LO;
						end else begin
							bytes_to_read = bytes_to_read - 8'd1;
							shift_reg = '0;
							bit_pos = '0;
							bus_phase = PH_RX_LO;
						end
					end
					PH_SP_LO: bus_phase = PH_SP_HI;
					PH_SP_HI: bus_phase = PH_SP_REL;
					default: begin
						o.done_res = 1'b1;
						o.ack_error = nack_seen;
						bus_phase = PH_IDLE;
					end
				endcase
			end
		end
		return o;
	endfunction

	// Build the next tick from what the bus is doing right now.
	function automatic req_t make_tick();
		req_t t;
		t.req_type = 1'($urandom_range(0, 1));
		t.target_reg = 8'($urandom);
		t.wr_data = 8'($urandom);
		t.byte_count = 8'($urandom);
		if (bus_phase == PH_IDLE) begin
			t.start_request = $urandom_range(0, 99) < start_pct;
			if (t.start_request)
				slave_absent = $urandom_range(0, 99) < absent_pct;
			t.byte_count = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
		end else begin
			t.start_request = 1'($urandom_range(0, 1));
		end
		// The slave acknowledges most of the time, sometimes a few ticks late.
		if (bus_phase == PH_ACK_HI)
			t.sda_in = slave_absent || ($urandom_range(0, 99) < 20);
		else
			t.sda_in = 1'($urandom_range(0, 1));
		return t;
	endfunction

	function automatic string show_levels(input res_t r);
		return $sformatf("scl=%b pull=%b busy=%b rd_valid=%b rd_data=%h rd_last=%b done=%b err=%b",
			r.scl_level, r.sda_pull_low, r.busy_res, r.rd_valid, r.rd_data, r.rd_last,
			r.done_res, r.ack_error);
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// Offer one tick and record its expected bus levels once the transaction completes.
	task automatic send_tick(input req_t t);
		int unsigned gap;
		gap = $urandom_range(0, req_max_gap);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= t;
		do @(posedge clk); while (!req.ready);
		bus_outputs_due.push_back(advance_bus(t));
	endtask

	// Registers change only with no tick in flight.
	task automatic write_cfg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
		req.valid <= 1'b0;
		@(posedge clk);
		while (bus_outputs_due.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEVICE_ADDRESS: dev_addr = value[6:0];
			CFG_HALF_BIT_TICKS: half_bit = value;
			CFG_ACK_POLL_LIMIT: poll_limit = value[7:0];
			default: ;
		endcase
	endtask

	// Finish any bus transfer under way, start a new one and tick it to the end.
	task automatic run_transfer(input logic kind, input logic [7:0] reg_a,
		input logic [7:0] data, input logic [7:0] count, input logic absent);
		req_t t;
		while (bus_phase != PH_IDLE) send_tick(make_tick());
		t.start_request = 1'b1;
		t.req_type = kind;
		t.target_reg = reg_a;
		t.wr_data = data;
		t.byte_count = count;
		t.sda_in = 1'($urandom_range(0, 1));
		slave_absent = absent;
		send_tick(t);
		while (bus_phase != PH_IDLE) send_tick(make_tick());
	endtask

	// Reset register values: address 104, ten ticks per half bit, 250 ACK polls.
	task automatic test_reset_defaults();
		run_transfer(REQ_WRITE, 8'hFF, 8'h00, 8'd1, 1'b1);
	endtask

	// Zero and full-scale address and ACK poll limit, zero and unit half bit, zero and multi-byte bursts, ACK timeouts.
	task automatic test_register_extremes();
		write_cfg(CFG_DEVICE_ADDRESS, 16'd0);
		write_cfg(CFG_HALF_BIT_TICKS, 16'd0);
		write_cfg(CFG_ACK_POLL_LIMIT, 16'd0);
		run_transfer(REQ_WRITE, 8'h00, 8'hFF, 8'd1, 1'b0);
		run_transfer(REQ_READ, 8'hA5, 8'h5A, 8'd0, 1'b0);
		run_transfer(REQ_WRITE, 8'h3C, 8'hC3, 8'd1, 1'b1);

		write_cfg(CFG_DEVICE_ADDRESS, 16'd127);
		write_cfg(CFG_HALF_BIT_TICKS, 16'd1);
		write_cfg(CFG_ACK_POLL_LIMIT, 16'd255);
		// An unknown index must leave every register alone.
		write_cfg(CFG_UNUSED_INDEX, 16'hFFFF);
		req_max_gap = 0;
		res_max_stall = 0;
		run_transfer(REQ_READ, 8'h80, 8'h7F, 8'd6, 1'b0);
		req_max_gap = 15;
		res_max_stall = 15;
		run_transfer(REQ_READ, 8'h01, 8'h01, 8'd3, 1'b1);
	endtask

	// Longest half bit, then a shorter one written in the middle of a bus transfer.
	task automatic test_slow_half_bit();
		req_t t;
		write_cfg(CFG_HALF_BIT_TICKS, 16'hFFFF);
		write_cfg(CFG_ACK_POLL_LIMIT, 16'd4);
		t = make_tick();
		t.start_request = 1'b1;
		send_tick(t);
		repeat (40) send_tick(make_tick());
		write_cfg(CFG_HALF_BIT_TICKS, 16'd2);
		while (bus_phase != PH_IDLE) send_tick(make_tick());
		write_cfg(CFG_HALF_BIT_TICKS, 16'd1);
	endtask

	// Random bus traffic in segments, each with its own settings and idling pattern.
	task automatic test_random_traffic();
		int seg;
		for (seg = 0; seg < 8; seg++) begin
			req_max_gap = (seg % 4 < 2) ? 15 : 0;
			res_max_stall = (seg % 2 == 0) ? 15 : 0;
			write_cfg(CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
			write_cfg(CFG_HALF_BIT_TICKS, 16'((seg == 5) ? $urandom_range(4, 8)
				: $urandom_range(1, 3)));
			write_cfg(CFG_ACK_POLL_LIMIT, 16'((seg == 6) ? $urandom_range(20, 60)
				: $urandom_range(1, 6)));
			repeat (40) send_tick(make_tick());
		end
	endtask

	// Result side: stall at random, then take one transaction.
	initial begin : result_ready
		int unsigned stall;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, res_max_stall);
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			ticks_checked++;
			if (bus_outputs_due.size() == 0) begin
				note_failure($sformatf("tick %0d: unexpected result %s", ticks_checked,
					show_levels(res.data)));
			end else begin
				want = bus_outputs_due.pop_front();
				if (res.data.scl_level !== want.scl_level
					|| res.data.sda_pull_low !== want.sda_pull_low
					|| res.data.busy_res !== want.busy_res
					|| res.data.rd_valid !== want.rd_valid
					|| res.data.rd_data !== want.rd_data
					|| res.data.rd_last !== want.rd_last
					|| res.data.done_res !== want.done_res
					|| res.data.ack_error !== want.ack_error)
					note_failure($sformatf("tick %0d: expected %s, got %s", ticks_checked,
						show_levels(want), show_levels(res.data)));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_slow_half_bit();
		test_random_traffic();

		// Let every owed result arrive, then watch a little longer for strays.
		req.valid <= 1'b0;
		while (bus_outputs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && bus_outputs_due.size() == 0)
			$display("PASS i2c_register_master");
		else
			$display("FAIL i2c_register_master");
		$finish;
	end

endmodule
